>>> rtl/core/r5sfft_pkg.sv
// Package for the radix-5 Stockham FFT: shared types, Q16 constants,
// twiddle ROM and the 24-bit saturation helper. No dependencies.
`timescale 1ns / 1ps

package r5sfft_pkg;

    // Default sizing handed to the top-level parameters
    localparam int MAX_POINTS_D  = 25;
    localparam int MAX_STAGES_D  = 2;
    localparam int SAMPLE_BITS_D = 16;

    // Fixed widths of the stored data and of counters / indexes
    localparam int DW  = 24;
    localparam int CW  = 5;
    localparam int YW  = 46;
    localparam int ROM_SIZE = 25;

    // Butterfly constants, Q16
    localparam logic signed [17:0] Q_SIN1    = 18'sd62328;
    localparam logic signed [17:0] Q_SQRT5_4 = 18'sd36636;
    localparam logic signed [17:0] Q_RATIO   = 18'sd40503;

    localparam logic signed [DW-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [DW-1:0] OUT_MIN = -24'sh800000;

    typedef logic signed [DW-1:0] t_data;
    typedef logic [CW-1:0]        t_idx;

    typedef struct packed {
        t_data re;
        t_data im;
    } t_cplx;

    typedef struct packed {
        logic  we;
        logic  bank;
        t_idx  addr;
        t_cplx data;
    } t_mem_wr;

    typedef struct packed {
        logic re;
        logic bank;
        t_idx addr;
    } t_mem_rd;

    typedef struct packed {
        logic       cap_en;
        logic [2:0] cap_idx;
        logic [2:0] tw_sel;
        t_idx       tw_exp;
    } t_bf_ctrl;

    // Clamp a wide signed value to 24 bits
    function automatic t_data sat_data(input logic signed [65:0] x);
        t_data r;
        if (x > 66'(OUT_MAX))      r = OUT_MAX;
        else if (x < 66'(OUT_MIN)) r = OUT_MIN;
        else                       r = DW'(x);
        return r;
    endfunction

    // Real part of exp(-2 pi i e / 25), Q16
    function automatic logic signed [17:0] tw_re(input t_idx e);
        logic signed [17:0] r;
        unique case (e)
            5'd0:  r = 18'sd65536;
            5'd1:  r = 18'sd63477;
            5'd2:  r = 18'sd57430;
            5'd3:  r = 18'sd47774;
            5'd4:  r = 18'sd35116;
            5'd5:  r = 18'sd20252;
            5'd6:  r = 18'sd4115;
            5'd7:  r = -18'sd12280;
            5'd8:  r = -18'sd27904;
            5'd9:  r = -18'sd41774;
            5'd10: r = -18'sd53020;
            5'd11: r = -18'sd60934;
            5'd12: r = -18'sd65019;
            5'd13: r = -18'sd65019;
            5'd14: r = -18'sd60934;
            5'd15: r = -18'sd53020;
            5'd16: r = -18'sd41774;
            5'd17: r = -18'sd27904;
            5'd18: r = -18'sd12280;
            5'd19: r = 18'sd4115;
            5'd20: r = 18'sd20252;
            5'd21: r = 18'sd35116;
            5'd22: r = 18'sd47774;
            5'd23: r = 18'sd57430;
            5'd24: r = 18'sd63477;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // Imaginary part of exp(-2 pi i e / 25), Q16
    function automatic logic signed [17:0] tw_im(input t_idx e);
        logic signed [17:0] r;
        unique case (e)
            5'd0:  r = 18'sd0;
            5'd1:  r = -18'sd16298;
            5'd2:  r = -18'sd31572;
            5'd3:  r = -18'sd44862;
            5'd4:  r = -18'sd55334;
            5'd5:  r = -18'sd62328;
            5'd6:  r = -18'sd65407;
            5'd7:  r = -18'sd64375;
            5'd8:  r = -18'sd59299;
            5'd9:  r = -18'sd50496;
            5'd10: r = -18'sd38521;
            5'd11: r = -18'sd24125;
            5'd12: r = -18'sd8214;
            5'd13: r = 18'sd8214;
            5'd14: r = 18'sd24125;
            5'd15: r = 18'sd38521;
            5'd16: r = 18'sd50496;
            5'd17: r = 18'sd59299;
            5'd18: r = 18'sd64375;
            5'd19: r = 18'sd65407;
            5'd20: r = 18'sd62328;
            5'd21: r = 18'sd55334;
            5'd22: r = 18'sd44862;
            5'd23: r = 18'sd31572;
            5'd24: r = 18'sd16298;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/r5sfft_mem.sv
// Ping-pong sample store: two banks, one write and one registered read a cycle.
// Depends on r5sfft_pkg.
`timescale 1ns / 1ps

module r5sfft_mem #(
    parameter int DEPTH = r5sfft_pkg::MAX_POINTS_D
) (
    input  logic                i_clk,
    input  r5sfft_pkg::t_mem_wr i_wr,
    input  r5sfft_pkg::t_mem_rd i_rd,
    output r5sfft_pkg::t_cplx   o_rdata
);
    import r5sfft_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cplx r_mem_a [DEPTH];
    t_cplx r_mem_b [DEPTH];
    t_cplx r_rdata;

    // Write the selected bank
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            if (i_wr.bank) r_mem_b[i_wr.addr[AW-1:0]] <= i_wr.data;
            else           r_mem_a[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    // Read the selected bank, hold data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rdata <= i_rd.bank ? r_mem_b[i_rd.addr[AW-1:0]] : r_mem_a[i_rd.addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/r5sfft_bfly.sv
// Radix-5 butterfly datapath: operand capture, three arithmetic stages and
// a twiddle multiplier. Depends on r5sfft_pkg.
`timescale 1ns / 1ps

module r5sfft_bfly (
    input  logic                 i_clk,
    input  r5sfft_pkg::t_bf_ctrl i_ctrl,
    input  r5sfft_pkg::t_cplx    i_rdata,
    output r5sfft_pkg::t_cplx    o_wdata
);
    import r5sfft_pkg::*;

    // Operands, part 0 real and part 1 imaginary
    t_data r_c [5][2];

    logic signed [24:0] a_d0 [2];
    logic signed [24:0] a_d1 [2];
    logic signed [24:0] a_s14 [2];
    logic signed [24:0] a_s23 [2];
    logic signed [25:0] a_d4 [2];
    logic signed [25:0] a_s01 [2];
    logic signed [42:0] a_d2 [2];
    logic signed [42:0] a_d3 [2];
    logic signed [43:0] a_d5 [2];
    logic signed [42:0] a_d6 [2];
    t_data              a_dc [2];

    logic signed [42:0] r_d2 [2];
    logic signed [42:0] r_d3 [2];
    logic signed [43:0] r_d5 [2];
    logic signed [42:0] r_d6 [2];
    t_data              r_dc [2];

    logic signed [60:0] b_p2 [2];
    logic signed [60:0] b_p3 [2];
    logic signed [44:0] b_d7 [2];
    logic signed [44:0] b_d8 [2];

    logic signed [60:0] r_p2 [2];
    logic signed [60:0] r_p3 [2];
    logic signed [44:0] r_d7 [2];
    logic signed [44:0] r_d8 [2];
    logic signed [42:0] r_d2q [2];
    logic signed [42:0] r_d3q [2];
    t_data              r_dcq [2];

    logic signed [44:0] c_t [2];
    logic signed [44:0] c_u [2];
    logic signed [YW-1:0] c_y [4][2];
    logic signed [YW-1:0] r_y [4][2];

    logic signed [YW-1:0] w_yre, w_yim;
    logic signed [17:0]   w_wr, w_wi;
    logic signed [63:0]   r_mrr, r_mii, r_mri, r_mir;
    logic [2:0]           r_pk;
    logic signed [65:0]   w_sre, w_sim;

    // Capture operands as read data returns
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap_en) begin
            r_c[i_ctrl.cap_idx][0] <= i_rdata.re;
            r_c[i_ctrl.cap_idx][1] <= i_rdata.im;
        end
    end

    // Stage A: sums, differences and constant products
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            a_d0[p]  = 25'(r_c[1][p]) + 25'(r_c[4][p]);
            a_d1[p]  = 25'(r_c[2][p]) + 25'(r_c[3][p]);
            a_s14[p] = 25'(r_c[1][p]) - 25'(r_c[4][p]);
            a_s23[p] = 25'(r_c[2][p]) - 25'(r_c[3][p]);
            a_d4[p]  = 26'(a_d0[p]) + 26'(a_d1[p]);
            a_s01[p] = 26'(a_d0[p]) - 26'(a_d1[p]);
            a_d2[p]  = 43'(a_s14[p]) * 43'(Q_SIN1);
            a_d3[p]  = 43'(a_s23[p]) * 43'(Q_SIN1);
            a_d5[p]  = 44'(a_s01[p]) * 44'(Q_SQRT5_4);
            a_d6[p]  = (43'(r_c[0][p]) <<< 16) - (43'(a_d4[p]) <<< 14);
            a_dc[p]  = sat_data(66'(r_c[0][p]) + 66'(a_d4[p]));
        end
    end

    // Stage B: ratio products and the two center terms
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            b_p2[p] = 61'(r_d2[p]) * 61'(Q_RATIO);
            b_p3[p] = 61'(r_d3[p]) * 61'(Q_RATIO);
            b_d7[p] = 45'(r_d6[p]) + 45'(r_d5[p]);
            b_d8[p] = 45'(r_d6[p]) - 45'(r_d5[p]);
        end
    end

    // Stage C: round ratio products, rotate by -i and combine
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            c_t[p] = 45'(r_d2q[p]) + 45'((r_p3[p] + 61'sd32768) >>> 16);
            c_u[p] = 45'((r_p2[p] + 61'sd32768) >>> 16) - 45'(r_d3q[p]);
        end
        c_y[0][0] = YW'(r_d7[0]) + YW'(c_t[1]);
        c_y[0][1] = YW'(r_d7[1]) - YW'(c_t[0]);
        c_y[1][0] = YW'(r_d8[0]) + YW'(c_u[1]);
        c_y[1][1] = YW'(r_d8[1]) - YW'(c_u[0]);
        c_y[2][0] = YW'(r_d8[0]) - YW'(c_u[1]);
        c_y[2][1] = YW'(r_d8[1]) + YW'(c_u[0]);
        c_y[3][0] = YW'(r_d7[0]) - YW'(c_t[1]);
        c_y[3][1] = YW'(r_d7[1]) + YW'(c_t[0]);
    end

    // Advance the pipeline every cycle; operands hold while results drain
    always_ff @(posedge i_clk) begin
        r_d2  <= a_d2;
        r_d3  <= a_d3;
        r_d5  <= a_d5;
        r_d6  <= a_d6;
        r_dc  <= a_dc;
        r_p2  <= b_p2;
        r_p3  <= b_p3;
        r_d7  <= b_d7;
        r_d8  <= b_d8;
        r_d2q <= r_d2;
        r_d3q <= r_d3;
        r_dcq <= r_dc;
        r_y   <= c_y;
    end

    // Select the output leg and its twiddle
    always_comb begin
        unique case (i_ctrl.tw_sel)
            3'd2:    begin w_yre = r_y[1][0]; w_yim = r_y[1][1]; end
            3'd3:    begin w_yre = r_y[2][0]; w_yim = r_y[2][1]; end
            3'd4:    begin w_yre = r_y[3][0]; w_yim = r_y[3][1]; end
            default: begin w_yre = r_y[0][0]; w_yim = r_y[0][1]; end
        endcase
        w_wr = tw_re(i_ctrl.tw_exp);
        w_wi = tw_im(i_ctrl.tw_exp);
    end

    // Twiddle partial products
    always_ff @(posedge i_clk) begin
        r_mrr <= 64'(w_yre) * 64'(w_wr);
        r_mii <= 64'(w_yim) * 64'(w_wi);
        r_mri <= 64'(w_yre) * 64'(w_wi);
        r_mir <= 64'(w_yim) * 64'(w_wr);
        r_pk  <= i_ctrl.tw_sel;
    end

    // Sum, round from Q32 and clamp; leg 0 passes the registered center sum instead
    always_comb begin
        w_sre = 66'(r_mrr) - 66'(r_mii) + 66'sd2147483648;
        w_sim = 66'(r_mri) + 66'(r_mir) + 66'sd2147483648;
        if (r_pk == 3'd0) begin
            o_wdata.re = r_dcq[0];
            o_wdata.im = r_dcq[1];
        end else begin
            o_wdata.re = sat_data(w_sre >>> 32);
            o_wdata.im = sat_data(w_sim >>> 32);
        end
    end

endmodule

>>> rtl/core/radix5_stockham_fft.sv
// Top level of the radix-5 Stockham FFT: load, pass sequencer and drain.
// Depends on r5sfft_pkg, r5sfft_mem and r5sfft_bfly.
//
//  channel  direction  handshake               payload
//  sample   in         i_valid / o_stall       i_sample_real, i_sample_imag, i_sample_last
//  bin      out        o_valid / i_stall       o_bin_real, o_bin_imag, o_bin_index, o_bin_last
//  config   in         i_cfg_valid/o_cfg_ready i_cfg_data (stage_count)
//
// Samples load one per cycle; the frame end adds a zero fill of the remaining addresses.
// Each butterfly reads its five operands, computes, then writes back its five results on the single
// memory port pair: 25 points take two passes of five butterflies, 5 points a single butterfly.
// Bins drain one per cycle through the output register while i_stall is low.
// Reset (synchronous, active low) clears control only; no clearing pass runs.
// o_stall is high from frame end until the last bin sits in the output register.
`timescale 1ns / 1ps

module radix5_stockham_fft #(
    parameter int MAX_POINTS  = r5sfft_pkg::MAX_POINTS_D,
    parameter int MAX_STAGES  = r5sfft_pkg::MAX_STAGES_D,
    parameter int SAMPLE_BITS = r5sfft_pkg::SAMPLE_BITS_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    input  logic                          i_sample_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output r5sfft_pkg::t_data             o_bin_real,
    output r5sfft_pkg::t_data             o_bin_imag,
    output r5sfft_pkg::t_idx              o_bin_index,
    output logic                          o_bin_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_data
);
    import r5sfft_pkg::*;

    localparam int STG_CAP = (MAX_STAGES >= 2 && MAX_POINTS >= 25) ? 2 : 1;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_DRN  = 3'd5;

    logic [2:0] r_state;
    logic [1:0] r_cfg;
    t_idx       r_cnt, r_np, r_lm, r_m, r_fill;
    t_idx       r_b, r_kk, r_o, r_step, r_sinc, r_ra, r_wa, r_e, r_da, r_pidx;
    logic       r_two, r_pass, r_sel, r_pend;
    logic [2:0] r_ri, r_wk, r_cap_i;
    logic [1:0] r_cc;
    logic       r_cap_v;
    logic       r_ov;
    t_data      r_ore, r_oim;
    t_idx       r_oidx;
    logic       r_olast;

    logic       w_accept, w_two_now, w_frame_end, w_load_now, w_issue;
    t_idx       w_np_now;
    logic [5:0] w_next_cnt;
    logic [5:0] w_e_sum, w_s_sum;
    t_mem_wr    w_wr;
    t_mem_rd    w_rd;
    t_cplx      w_rdata, w_bf_wdata;
    t_bf_ctrl   w_bf;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_LOAD);
    assign w_accept    = i_valid && !o_stall;

    // Frame size from the current register
    assign w_two_now   = (r_cfg >= 2'd2) && (STG_CAP == 2);
    assign w_np_now    = w_two_now ? 5'd25 : 5'd5;
    assign w_next_cnt  = {1'b0, r_cnt} + 6'd1;
    assign w_frame_end = i_sample_last || (w_next_cnt >= {1'b0, w_np_now});

    // Drain handshake: load the output register when free, refill the read
    assign w_load_now = r_pend && (!r_ov || !i_stall);
    assign w_issue    = (r_state == ST_DRN) && (r_da < r_np) && (!r_pend || w_load_now);

    // Twiddle exponent and step wrap modulo the ROM size
    assign w_e_sum = {1'b0, r_e} + {1'b0, r_step};
    assign w_s_sum = {1'b0, r_step} + {1'b0, r_sinc};

    // Memory write port mux
    always_comb begin
        w_wr.we      = 1'b0;
        w_wr.bank    = 1'b0;
        w_wr.addr    = r_cnt;
        w_wr.data.re = DW'(i_sample_real);
        w_wr.data.im = DW'(i_sample_imag);
        unique case (r_state)
            ST_LOAD: w_wr.we = w_accept && (r_cnt < w_np_now);
            ST_FILL: begin
                w_wr.we   = (r_fill < r_np);
                w_wr.addr = r_fill;
                w_wr.data = '0;
            end
            ST_WR: begin
                w_wr.we   = (r_wk != 3'd0);
                w_wr.bank = !r_sel;
                w_wr.addr = r_wa;
                w_wr.data = w_bf_wdata;
            end
            default: ;
        endcase
    end

    // Memory read port mux
    always_comb begin
        w_rd.bank = r_sel;
        w_rd.re   = (r_state == ST_RD) || w_issue;
        w_rd.addr = (r_state == ST_RD) ? r_ra : r_da;
    end

    // Butterfly control
    always_comb begin
        w_bf.cap_en  = r_cap_v;
        w_bf.cap_idx = r_cap_i;
        w_bf.tw_sel  = r_wk;
        w_bf.tw_exp  = r_e;
    end

    r5sfft_mem #(
        .DEPTH (MAX_POINTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_rdata (w_rdata)
    );

    r5sfft_bfly u_bfly (
        .i_clk   (i_clk),
        .i_ctrl  (w_bf),
        .i_rdata (w_rdata),
        .o_wdata (w_bf_wdata)
    );

    // Sequencer: load, fill, passes, drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cfg   <= 2'd2;
            r_cnt   <= '0;
            r_np    <= 5'd25;
            r_lm    <= 5'd5;
            r_m     <= 5'd1;
            r_fill  <= '0;
            r_b     <= '0;
            r_kk    <= '0;
            r_o     <= '0;
            r_step  <= '0;
            r_sinc  <= 5'd1;
            r_ra    <= '0;
            r_wa    <= '0;
            r_e     <= '0;
            r_da    <= '0;
            r_pidx  <= '0;
            r_two   <= 1'b1;
            r_pass  <= 1'b0;
            r_sel   <= 1'b0;
            r_pend  <= 1'b0;
            r_ri    <= '0;
            r_wk    <= '0;
            r_cc    <= '0;
            r_cap_v <= 1'b0;
            r_cap_i <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_cap_v <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_cfg <= i_cfg_data;

            // Output register: take from the drain, drop when taken
            if (w_load_now)              r_ov <= 1'b1;
            else if (r_ov && !i_stall)   r_ov <= 1'b0;

            unique case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (!w_frame_end) begin
                            r_cnt <= w_next_cnt[CW-1:0];
                        end else begin
                            r_cnt   <= '0;
                            r_np    <= w_np_now;
                            r_lm    <= w_two_now ? 5'd5 : 5'd1;
                            r_two   <= w_two_now;
                            r_fill  <= w_next_cnt[CW-1:0];
                            r_state <= ST_FILL;
                        end
                    end
                end
                ST_FILL: begin
                    if (r_fill < r_np) begin
                        r_fill <= r_fill + 5'd1;
                    end else begin
                        r_pass  <= 1'b0;
                        r_sel   <= 1'b0;
                        r_m     <= 5'd1;
                        r_b     <= '0;
                        r_kk    <= '0;
                        r_o     <= '0;
                        r_step  <= '0;
                        r_sinc  <= r_two ? 5'd1 : 5'd5;
                        r_ra    <= '0;
                        r_ri    <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_ra    <= r_ra + r_lm;
                    r_ri    <= r_ri + 3'd1;
                    r_cap_v <= 1'b1;
                    r_cap_i <= r_ri;
                    if (r_ri == 3'd4) begin
                        r_cc    <= '0;
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    r_cc <= r_cc + 2'd1;
                    if (r_cc == 2'd3) begin
                        r_wk    <= '0;
                        r_e     <= '0;
                        r_wa    <= r_o;
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    r_wk <= r_wk + 3'd1;
                    r_e  <= (w_e_sum >= 6'(ROM_SIZE)) ? 5'(w_e_sum - 6'(ROM_SIZE))
                                                      : w_e_sum[CW-1:0];
                    if (r_wk != 3'd0) r_wa <= r_wa + r_m;
                    if (r_wk == 3'd5) begin
                        r_ri <= '0;
                        if (r_b == r_lm - 5'd1) begin
                            r_sel <= !r_sel;
                            if (r_pass || !r_two) begin
                                r_da    <= '0;
                                r_pend  <= 1'b0;
                                r_state <= ST_DRN;
                            end else begin
                                r_pass  <= 1'b1;
                                r_m     <= 5'd5;
                                r_b     <= '0;
                                r_kk    <= '0;
                                r_o     <= '0;
                                r_step  <= '0;
                                r_sinc  <= 5'd5;
                                r_ra    <= '0;
                                r_state <= ST_RD;
                            end
                        end else begin
                            r_b     <= r_b + 5'd1;
                            r_ra    <= r_b + 5'd1;
                            r_state <= ST_RD;
                            if (r_kk == r_m - 5'd1) begin
                                r_kk   <= '0;
                                r_o    <= r_o + 5'd1 + (r_m << 2);
                                r_step <= (w_s_sum >= 6'(ROM_SIZE))
                                          ? 5'(w_s_sum - 6'(ROM_SIZE)) : w_s_sum[CW-1:0];
                            end else begin
                                r_kk <= r_kk + 5'd1;
                                r_o  <= r_o + 5'd1;
                            end
                        end
                    end
                end
                ST_DRN: begin
                    if (w_issue) begin
                        r_da   <= r_da + 5'd1;
                        r_pidx <= r_da;
                        r_pend <= 1'b1;
                    end else if (w_load_now) begin
                        r_pend <= 1'b0;
                    end
                    if ((r_da == r_np) && (!r_pend || w_load_now)) r_state <= ST_LOAD;
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_load_now) begin
            r_ore   <= w_rdata.re;
            r_oim   <= w_rdata.im;
            r_oidx  <= r_pidx;
            r_olast <= (r_pidx == r_np - 5'd1);
        end
    end

    assign o_valid     = r_ov;
    assign o_bin_real  = r_ore;
    assign o_bin_imag  = r_oim;
    assign o_bin_index = r_oidx;
    assign o_bin_last  = r_olast;

`ifndef SYNTH
    // A bin on the output never lies beyond the frame
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bin_index < r_np))
        else $error("bin index beyond frame length");

    // Butterfly write-back never lands in the bank being read
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.we && r_state == ST_WR) |-> (w_wr.bank != r_sel))
        else $error("write-back into source bank");

    // Operand reads stay inside the frame
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_ra < r_np))
        else $error("operand read beyond frame length");

    // A pending drain read is never lost while the output is stalled
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_ov && i_stall) |=> r_pend)
        else $error("pending bin dropped under stall");
`endif

endmodule

>>> sim/r5sfft_checker.sv
// Checker for the radix-5 Stockham FFT: watches the sample, bin and config
// channels, predicts every bin and compares. Depends on r5sfft_pkg.
`timescale 1ns / 1ps

module r5sfft_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_in_stall,
    input  logic signed [15:0]       i_sample_real,
    input  logic signed [15:0]       i_sample_imag,
    input  logic                     i_sample_last,
    input  logic                     i_out_valid,
    input  logic                     i_stall,
    input  r5sfft_pkg::t_data        i_bin_real,
    input  r5sfft_pkg::t_data        i_bin_imag,
    input  r5sfft_pkg::t_idx         i_bin_index,
    input  logic                     i_bin_last,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [1:0]               i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);
    import r5sfft_pkg::*;

    localparam longint K_SIN1    = 62328;
    localparam longint K_SQRT5_4 = 36636;
    localparam longint K_RATIO   = 40503;
    localparam longint K_QUARTER = 16384;

    typedef struct {
        longint re;
        longint im;
    } t_cnum;

    typedef struct {
        t_data re;
        t_data im;
        t_idx  idx;
        logic  last;
    } t_bin;

    // Twiddle table, exp(-2 pi i e/25) in Q16
    const longint cos_q16[25] = '{65536, 63477, 57430, 47774, 35116, 20252, 4115,
        -12280, -27904, -41774, -53020, -60934, -65019, -65019, -60934, -53020,
        -41774, -27904, -12280, 4115, 20252, 35116, 47774, 57430, 63477};
    const longint sin_q16[25] = '{0, -16298, -31572, -44862, -55334, -62328,
        -65407, -64375, -59299, -50496, -38521, -24125, -8214, 8214, 24125,
        38521, 50496, 59299, 64375, 65407, 62328, 55334, 44862, 31572, 16298};

    t_cnum     bank_a [25];
    t_cnum     bank_b [25];
    int        fill_count;
    logic [1:0] stage_reg;
    t_bin      bin_queue [$];

    function automatic longint round_shift(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp24(longint x);
        if (x > 8388607) return 8388607;
        if (x < -8388608) return -8388608;
        return x;
    endfunction

    function automatic t_cnum rotate(t_cnum a, int e);
        t_cnum r;
        longint wr, wi;
        wr = cos_q16[e % 25];
        wi = sin_q16[e % 25];
        r.re = clamp24(round_shift(a.re * wr - a.im * wi, 32));
        r.im = clamp24(round_shift(a.re * wi + a.im * wr, 32));
        return r;
    endfunction

    // One radix-5 pass from bank_a into bank_b (to_b) or back
    task automatic radix5_pass(bit to_b, int npts, int l, int m);
        t_cnum s [25];
        t_cnum d [25];
        t_cnum c0, c1, c2, c3, c4, d2, d3, d5, d6, d7, d8, t, u, d9, d10, y;
        longint d0r, d0i, d1r, d1i, d4r, d4i;
        int b, lm, o, stp;
        if (to_b) begin
            s = bank_a;
            d = bank_b;
        end else begin
            s = bank_b;
            d = bank_a;
        end
        for (int j = 0; j < l; j++) begin
            for (int k = 0; k < m; k++) begin
                b = k + j * m;
                lm = l * m;
                c0 = s[b]; c1 = s[b + lm]; c2 = s[b + 2 * lm];
                c3 = s[b + 3 * lm]; c4 = s[b + 4 * lm];
                d0r = c1.re + c4.re; d0i = c1.im + c4.im;
                d1r = c2.re + c3.re; d1i = c2.im + c3.im;
                d4r = d0r + d1r; d4i = d0i + d1i;
                o = k + 5 * j * m;
                stp = (25 / npts) * j * m;
                d2.re = (c1.re - c4.re) * K_SIN1; d2.im = (c1.im - c4.im) * K_SIN1;
                d3.re = (c2.re - c3.re) * K_SIN1; d3.im = (c2.im - c3.im) * K_SIN1;
                d5.re = (d0r - d1r) * K_SQRT5_4;  d5.im = (d0i - d1i) * K_SQRT5_4;
                d6.re = c0.re * 65536 - d4r * K_QUARTER;
                d6.im = c0.im * 65536 - d4i * K_QUARTER;
                d7.re = d6.re + d5.re; d7.im = d6.im + d5.im;
                d8.re = d6.re - d5.re; d8.im = d6.im - d5.im;
                t.re = d2.re + round_shift(d3.re * K_RATIO, 16);
                t.im = d2.im + round_shift(d3.im * K_RATIO, 16);
                u.re = round_shift(d2.re * K_RATIO, 16) - d3.re;
                u.im = round_shift(d2.im * K_RATIO, 16) - d3.im;
                d9.re = t.im;  d9.im = -t.re;
                d10.re = u.im; d10.im = -u.re;
                d[o].re = clamp24(c0.re + d4r);
                d[o].im = clamp24(c0.im + d4i);
                y.re = d7.re + d9.re;  y.im = d7.im + d9.im;
                d[o + m] = rotate(y, stp);
                y.re = d8.re + d10.re; y.im = d8.im + d10.im;
                d[o + 2 * m] = rotate(y, 2 * stp);
                y.re = d8.re - d10.re; y.im = d8.im - d10.im;
                d[o + 3 * m] = rotate(y, 3 * stp);
                y.re = d7.re - d9.re;  y.im = d7.im - d9.im;
                d[o + 4 * m] = rotate(y, 4 * stp);
            end
        end
        if (to_b) bank_b = d;
        else      bank_a = d;
    endtask

    // Load one sample; at frame end run the passes and queue all bins
    task automatic predict_bins(longint re, longint im, logic last);
        int stages, npts, nxt;
        t_bin bn;
        stages = (stage_reg == 0) ? 1 : (stage_reg > 2) ? 2 : int'(stage_reg);
        npts = (stages == 1) ? 5 : 25;
        if (fill_count < npts) begin
            bank_a[fill_count].re = re;
            bank_a[fill_count].im = im;
        end
        nxt = fill_count + 1;
        if (!last && nxt < npts) begin
            fill_count = nxt;
            return;
        end
        for (int i = nxt; i < npts; i++) begin
            bank_a[i].re = 0;
            bank_a[i].im = 0;
        end
        radix5_pass(1'b1, npts, npts / 5, 1);
        if (stages == 2) radix5_pass(1'b0, npts, 1, 5);
        for (int i = 0; i < npts; i++) begin
            bn.re   = (stages == 2) ? t_data'(bank_a[i].re) : t_data'(bank_b[i].re);
            bn.im   = (stages == 2) ? t_data'(bank_a[i].im) : t_data'(bank_b[i].im);
            bn.idx  = t_idx'(i);
            bn.last = (i + 1 == npts);
            bin_queue.push_back(bn);
        end
        fill_count = 0;
    endtask

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Track every transaction on the three channels
    always @(posedge i_clk) begin
        t_bin ex;
        if (!i_rst_n) begin
            fill_count = 0;
            stage_reg  = 2'd2;
            for (int i = 0; i < 25; i++) begin
                bank_a[i] = '{0, 0};
                bank_b[i] = '{0, 0};
            end
            bin_queue.delete();
        end else begin
            if (i_out_valid && !i_stall) begin
                if (bin_queue.size() == 0) begin
                    report($sformatf("bin %0d with nothing predicted", i_bin_index));
                end else begin
                    ex = bin_queue.pop_front();
                    if (i_bin_real !== ex.re)
                        report($sformatf("bin %0d real %0d, want %0d",
                                         ex.idx, i_bin_real, ex.re));
                    if (i_bin_imag !== ex.im)
                        report($sformatf("bin %0d imag %0d, want %0d",
                                         ex.idx, i_bin_imag, ex.im));
                    if (i_bin_index !== ex.idx)
                        report($sformatf("bin index %0d, want %0d", i_bin_index, ex.idx));
                    if (i_bin_last !== ex.last)
                        report($sformatf("bin %0d last flag %0b, want %0b",
                                         ex.idx, i_bin_last, ex.last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) stage_reg = i_cfg_data;
            if (i_valid && !i_in_stall)
                predict_bins(longint'(i_sample_real), longint'(i_sample_imag),
                             i_sample_last);
        end
        o_pending = bin_queue.size();
    end

endmodule

>>> sim/tb_radix5_stockham_fft.sv
// Testbench top for the radix-5 Stockham FFT: clock, reset, sample and
// config stimulus, bin stalls and verdict. Depends on r5sfft_pkg and r5sfft_checker.
`timescale 1ns / 1ps

module tb_radix5_stockham_fft;
    import r5sfft_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic signed [15:0] i_sample_real = '0;
    logic signed [15:0] i_sample_imag = '0;
    logic               i_sample_last = 1'b0;
    logic               i_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [1:0]         i_cfg_data = 2'd2;
    logic               o_stall, o_valid, o_bin_last, o_cfg_ready;
    t_data              o_bin_real, o_bin_imag;
    t_idx               o_bin_index;
    int                 fail_count, pending;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 sent_count = 0;
    logic [1:0]         stage_sel = 2'd2;

    always #6 i_clk = ~i_clk;

    radix5_stockham_fft dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sample_real, .i_sample_imag,
        .i_sample_last, .o_valid, .i_stall, .o_bin_real, .o_bin_imag,
        .o_bin_index, .o_bin_last, .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    r5sfft_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_sample_real,
        .i_sample_imag, .i_sample_last, .i_out_valid(o_valid), .i_stall,
        .i_bin_real(o_bin_real), .i_bin_imag(o_bin_imag), .i_bin_index(o_bin_index),
        .i_bin_last(o_bin_last), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** radix5_stockham_fft: FAILED **");
            $finish;
        end
    end

    // Receiver stalls: free-running, light random, or long runs, switching modes
    int stall_mode = 0;
    int stall_run = 0;
    always @(posedge i_clk) begin
        if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 3);
            default: begin
                if (stall_run == 0) begin
                    stall_run = $urandom_range(1, 12);
                    i_stall <= ~i_stall;
                end else begin
                    stall_run--;
                end
            end
        endcase
    end

    // Send one sample; returns at the edge that accepts it
    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im,
                               logic last);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_sample_real <= re;
        i_sample_imag <= im;
        i_sample_last <= last;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        sent_count++;
    endtask

    // Write the stage register once the block has gone quiet
    task automatic write_stages(logic [1:0] v);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (200) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        stage_sel = v;
    endtask

    function automatic logic [15:0] pick_value(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 511) - 256);
            default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    initial begin
        int npts, len, kind;
        logic end_flag;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short frame at the reset length: extremes, rest zero-filled
        send_sample(16'sh7FFF, -16'sh8000, 1'b0);
        send_sample(-16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sh0001, 16'shFFFF, 1'b1);
        // Five points: alternating extremes, then a one-sample frame
        write_stages(2'd1);
        for (int i = 0; i < 5; i++)
            send_sample(i[0] ? 16'sh7FFF : -16'sh8000, i[1] ? -16'sh8000 : 16'sh7FFF,
                        i == 4);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
        // Stage value zero acts as one; full frame ends without the last flag
        write_stages(2'd0);
        for (int i = 0; i < 5; i++) send_sample(-16'sh8000, -16'sh8000, 1'b0);
        // Stage value three acts as two; shrink the register mid-frame
        write_stages(2'd3);
        for (int i = 0; i < 7; i++) send_sample(16'(i * 4681), 16'(-i * 4681), 1'b0);
        write_stages(2'd1);
        send_sample(16'sh1234, 16'sh4321, 1'b0);

        // Random frames, mostly complete, some cut short
        while (sent_count < 250) begin
            if ($urandom_range(0, 2) == 0) write_stages(2'($urandom_range(0, 3)));
            npts = (stage_sel == 2'd1 || stage_sel == 2'd0) ? 5 : 25;
            kind = $urandom_range(0, 5);
            kind = (kind > 2) ? 0 : kind;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, npts - 1) : npts;
            end_flag = (len < npts) || ($urandom_range(0, 4) != 0);
            for (int i = 0; i < len; i++)
                send_sample(pick_value(kind), pick_value(kind),
                            (i == len - 1) ? end_flag : ($urandom_range(0, 99) == 0));
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** radix5_stockham_fft: PASSED **");
        end else begin
            $display("** radix5_stockham_fft: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/r5sfft_pkg.sv
rtl/core/r5sfft_mem.sv
rtl/core/r5sfft_bfly.sv
rtl/core/radix5_stockham_fft.sv
sim/r5sfft_checker.sv
sim/tb_radix5_stockham_fft.sv
